>>> hw/rtl/ppp_pkg.sv
// Shared types and constants for the palette pixel packet parser.
// No dependencies; used by ppp_parser and palette_pixel_packet_parser.
package ppp_pkg;

    // default store depths
    localparam int PALETTE_DEPTH_DEF = 255;
    localparam int PIXEL_DEPTH_DEF   = 255;

    // configuration register indexes
    localparam logic CFG_UPDATE_EN = 1'b0;
    localparam logic CFG_STATUS_EN = 1'b1;

    // packet opcodes
    localparam logic [7:0] OP_STATUS = 8'd0;
    localparam logic [7:0] OP_UPDATE = 8'd1;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_PIXEL  = 2'd2;

    // where the parser stands inside the current packet
    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_STAT_FIRST,
        PH_STAT_EXTRA,
        PH_PLEN,
        PH_DLEN,
        PH_PALETTE,
        PH_INDEX,
        PH_IGNORE
    } phase_t;

    // per-beat actions from the parser to the store pipeline
    typedef struct packed {
        logic        res_valid;
        logic [1:0]  res_kind;
        logic        status_on;
        logic [7:0]  pixel_count;
        logic        pal_wr;
        logic [7:0]  pal_wr_addr;
        logic [23:0] pal_wr_data;
        logic        pal_rd;
        logic [7:0]  pal_rd_addr;
        logic        pal_zero;
        logic        pix_wr;
        logic [7:0]  pix_wr_addr;
    } parse_act_t;

endpackage

>>> hw/rtl/ppp_parser.sv
// Packet byte parser: tracks the position in the current packet and
// issues palette/pixel store actions and results. Depends on ppp_pkg.
module ppp_parser #(
    parameter int PALETTE_DEPTH = ppp_pkg::PALETTE_DEPTH_DEF,
    parameter int PIXEL_DEPTH   = ppp_pkg::PIXEL_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic                update_enable,
    input  logic                status_enable,
    output ppp_pkg::parse_act_t act
);

    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);
    localparam logic [8:0] PIX_LIMIT = 9'(PIXEL_DEPTH);

    ppp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  plen_reg, plen_next;
    logic [7:0]  dlen_reg, dlen_next;
    logic [15:0] partial_reg, partial_next;
    logic [1:0]  comp_reg, comp_next;
    logic [7:0]  entry_reg, entry_next;
    logic [7:0]  didx_reg, didx_next;
    logic        err_reg, err_next;

    // shared terms
    logic       pal_last;
    logic [7:0] didx_inc;
    logic       idx_live;
    logic       idx_bad;

    assign pal_last = (comp_reg == 2'd2) && (entry_reg == plen_reg - 8'd1);
    assign didx_inc = (didx_reg == 8'hFF) ? didx_reg : didx_reg + 8'd1;
    assign idx_live = (didx_reg < dlen_reg) && !err_reg;
    assign idx_bad  = idx_live && (data_byte >= plen_reg);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ppp_pkg::PH_OPCODE;
            plen_reg    <= 8'd0;
            dlen_reg    <= 8'd0;
            partial_reg <= 16'd0;
            comp_reg    <= 2'd0;
            entry_reg   <= 8'd0;
            didx_reg    <= 8'd0;
            err_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            plen_reg    <= plen_next;
            dlen_reg    <= dlen_next;
            partial_reg <= partial_next;
            comp_reg    <= comp_next;
            entry_reg   <= entry_next;
            didx_reg    <= didx_next;
            err_reg     <= err_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        plen_next    = plen_reg;
        dlen_next    = dlen_reg;
        partial_next = partial_reg;
        comp_next    = comp_reg;
        entry_next   = entry_reg;
        didx_next    = didx_reg;
        err_next     = err_reg;
        if (byte_valid)
        begin
            unique case (phase_reg)
                ppp_pkg::PH_OPCODE:
                begin
                    err_next = 1'b0;
                    priority if (data_byte == ppp_pkg::OP_STATUS)
                        phase_next = ppp_pkg::PH_STAT_FIRST;
                    else if (data_byte == ppp_pkg::OP_UPDATE)
                        phase_next = ppp_pkg::PH_PLEN;
                    else
                        phase_next = ppp_pkg::PH_IGNORE;
                end
                ppp_pkg::PH_STAT_FIRST:
                    phase_next = ppp_pkg::PH_STAT_EXTRA;
                ppp_pkg::PH_STAT_EXTRA,
                ppp_pkg::PH_IGNORE:
                    phase_next = phase_reg;
                ppp_pkg::PH_PLEN:
                begin
                    plen_next  = data_byte;
                    phase_next = ppp_pkg::PH_DLEN;
                end
                ppp_pkg::PH_DLEN:
                begin
                    dlen_next  = data_byte;
                    comp_next  = 2'd0;
                    entry_next = 8'd0;
                    didx_next  = 8'd0;
                    phase_next = (plen_reg == 8'd0) ? ppp_pkg::PH_INDEX : ppp_pkg::PH_PALETTE;
                end
                ppp_pkg::PH_PALETTE:
                begin
                    unique case (comp_reg)
                        2'd0:
                        begin
                            partial_next[15:8] = data_byte;
                            comp_next          = 2'd1;
                        end
                        2'd1:
                        begin
                            partial_next[7:0] = data_byte;
                            comp_next         = 2'd2;
                        end
                        default:
                        begin
                            comp_next = 2'd0;
                            if (pal_last)
                                phase_next = ppp_pkg::PH_INDEX;
                            else
                                entry_next = entry_reg + 8'd1;
                        end
                    endcase
                end
                ppp_pkg::PH_INDEX:
                begin
                    if (idx_bad)
                        err_next = 1'b1;
                    didx_next = didx_inc;
                end
            endcase
            if (last_byte)
                phase_next = ppp_pkg::PH_OPCODE;
        end
    end

    // actions and results
    always_comb
    begin
        act = '0;
        if (byte_valid)
        begin
            unique case (phase_reg)
                ppp_pkg::PH_STAT_FIRST:
                begin
                    if (last_byte && status_enable)
                    begin
                        act.res_valid = 1'b1;
                        act.res_kind  = ppp_pkg::KIND_STATUS;
                        act.status_on = (data_byte != 8'd0);
                    end
                end
                ppp_pkg::PH_DLEN:
                begin
                    // empty palette and no indices: complete at the length byte
                    if (last_byte && update_enable && plen_reg == 8'd0 && data_byte == 8'd0)
                    begin
                        act.res_valid   = 1'b1;
                        act.res_kind    = ppp_pkg::KIND_UPDATE;
                        act.pixel_count = data_byte;
                    end
                end
                ppp_pkg::PH_PALETTE:
                begin
                    if (comp_reg == 2'd2 && {1'b0, entry_reg} < PAL_LIMIT)
                    begin
                        act.pal_wr      = 1'b1;
                        act.pal_wr_addr = entry_reg;
                        act.pal_wr_data = {partial_reg, data_byte};
                    end
                    if (last_byte && update_enable && pal_last && dlen_reg == 8'd0)
                    begin
                        act.res_valid   = 1'b1;
                        act.res_kind    = ppp_pkg::KIND_UPDATE;
                        act.pixel_count = dlen_reg;
                    end
                end
                ppp_pkg::PH_INDEX:
                begin
                    if (idx_live && !idx_bad && {1'b0, didx_reg} < PIX_LIMIT)
                    begin
                        act.pix_wr      = 1'b1;
                        act.pix_wr_addr = didx_reg;
                        act.pal_zero    = ({1'b0, data_byte} >= PAL_LIMIT);
                        act.pal_rd      = !act.pal_zero;
                        act.pal_rd_addr = data_byte;
                    end
                    if (last_byte && update_enable && !err_reg && !idx_bad &&
                        didx_inc >= dlen_reg)
                    begin
                        act.res_valid   = 1'b1;
                        act.res_kind    = ppp_pkg::KIND_UPDATE;
                        act.pixel_count = dlen_reg;
                    end
                end
                default:
                    act = '0;
            endcase
        end
    end

endmodule

>>> hw/rtl/palette_pixel_packet_parser.sv
// Top level of the palette pixel packet parser: config registers, palette
// and pixel memories, result pipeline. Depends on ppp_pkg and ppp_parser.
//
// The block takes one input beat per clock cycle while in_ready is high,
// packet bytes and pixel reads mixed in any order. Each beat passes one
// stage that holds the read of the palette or pixel memory, then an output
// register that returns the result; the pixel write of an index byte lands
// in the cycle after the byte, and a pixel read in that cycle is forwarded
// from the write. Input ready drops only while a result waits in both the
// stage and the output register. No clearing pass runs after reset: both
// memories are defined only where written.
module palette_pixel_packet_parser #(
    parameter int PALETTE_DEPTH = ppp_pkg::PALETTE_DEPTH_DEF,
    parameter int PIXEL_DEPTH   = ppp_pkg::PIXEL_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic [7:0] pixel_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic       status_on,
    output logic [7:0] pixel_count,
    output logic [7:0] color_first,
    output logic [7:0] color_second,
    output logic [7:0] color_third
);

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int PIX_AW = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
    localparam logic [8:0] PIX_LIMIT = 9'(PIXEL_DEPTH);

    logic update_enable_reg;
    logic status_enable_reg;

    logic                in_accept;
    logic                byte_valid;
    logic                pix_rd;
    logic                advance;
    ppp_pkg::parse_act_t act;

    logic [23:0] pal_mem [PALETTE_DEPTH];
    logic [23:0] pix_mem [PIXEL_DEPTH];
    logic [23:0] pal_rd_data_reg;
    logic [23:0] pix_rd_data_reg;
    logic [23:0] pix_wr_data;

    logic              s1_res_reg, s1_res_next;
    logic              s1_wr_reg;
    logic [PIX_AW-1:0] s1_wr_addr_reg;
    logic              s1_pal_zero_reg;
    logic [1:0]        s1_kind_reg;
    logic              s1_status_on_reg;
    logic [7:0]        s1_count_reg;
    logic              s1_pix_zero_reg;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] kind_reg;
    logic       status_on_reg;
    logic [7:0] pixel_count_reg;
    logic [7:0] color_first_reg;
    logic [7:0] color_second_reg;
    logic [7:0] color_third_reg;

    // handshake
    assign advance    = s1_res_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_res_reg || !out_valid_reg || out_ready;
    assign in_accept  = in_valid && in_ready;
    assign byte_valid = in_accept && !cmd;
    assign pix_rd     = in_accept && cmd && ({1'b0, pixel_index} < PIX_LIMIT);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            update_enable_reg <= 1'b0;
            status_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppp_pkg::CFG_UPDATE_EN: update_enable_reg <= cfg_data;
                ppp_pkg::CFG_STATUS_EN: status_enable_reg <= cfg_data;
            endcase
        end
    end

    ppp_parser #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .PIXEL_DEPTH   (PIXEL_DEPTH)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .update_enable (update_enable_reg),
        .status_enable (status_enable_reg),
        .act           (act)
    );

    // palette memory: written by palette bytes, read by index bytes
    always_ff @(posedge clk)
    begin
        if (act.pal_wr)
            pal_mem[act.pal_wr_addr[PAL_AW-1:0]] <= act.pal_wr_data;
        if (act.pal_rd)
            pal_rd_data_reg <= pal_mem[act.pal_rd_addr[PAL_AW-1:0]];
    end

    assign pix_wr_data = s1_pal_zero_reg ? 24'd0 : pal_rd_data_reg;

    // pixel memory: written in the cycle after the index byte, read forwards it
    always_ff @(posedge clk)
    begin
        if (s1_wr_reg)
            pix_mem[s1_wr_addr_reg] <= pix_wr_data;
        if (pix_rd)
        begin
            if (s1_wr_reg && s1_wr_addr_reg == pixel_index[PIX_AW-1:0])
                pix_rd_data_reg <= pix_wr_data;
            else
                pix_rd_data_reg <= pix_mem[pixel_index[PIX_AW-1:0]];
        end
    end

    // stage one control
    always_comb
    begin
        priority if (in_accept)
            s1_res_next = cmd || act.res_valid;
        else if (advance)
            s1_res_next = 1'b0;
        else
            s1_res_next = s1_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_res_reg <= 1'b0;
            s1_wr_reg  <= 1'b0;
        end
        else
        begin
            s1_res_reg <= s1_res_next;
            s1_wr_reg  <= byte_valid && act.pix_wr;
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_wr_addr_reg   <= act.pix_wr_addr[PIX_AW-1:0];
            s1_pal_zero_reg  <= act.pal_zero;
            s1_kind_reg      <= cmd ? ppp_pkg::KIND_PIXEL : act.res_kind;
            s1_status_on_reg <= act.status_on;
            s1_count_reg     <= act.pixel_count;
            s1_pix_zero_reg  <= !pix_rd;
        end
    end

    // output register control
    always_comb
    begin
        priority if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg        <= s1_kind_reg;
            status_on_reg   <= s1_status_on_reg;
            pixel_count_reg <= s1_count_reg;
            if (s1_kind_reg == ppp_pkg::KIND_PIXEL && !s1_pix_zero_reg)
            begin
                color_first_reg  <= pix_rd_data_reg[23:16];
                color_second_reg <= pix_rd_data_reg[15:8];
                color_third_reg  <= pix_rd_data_reg[7:0];
            end
            else
            begin
                color_first_reg  <= 8'd0;
                color_second_reg <= 8'd0;
                color_third_reg  <= 8'd0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign status_on    = status_on_reg;
    assign pixel_count  = pixel_count_reg;
    assign color_first  = color_first_reg;
    assign color_second = color_second_reg;
    assign color_third  = color_third_reg;

`ifndef ASSERT_OFF
    // a pixel write follows an accepted packet byte in the next cycle
    a_pix_wr_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        s1_wr_reg |-> $past(in_valid && in_ready && !cmd))
        else $error("pixel write without a preceding packet byte");

    // a pixel read always yields a pixel result in the stage
    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd) |=> (s1_res_reg && s1_kind_reg == ppp_pkg::KIND_PIXEL))
        else $error("pixel read lost in stage one");

    // a new output beat comes only from a waiting stage result
    a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_res_reg))
        else $error("output beat without stage result");
`endif

endmodule

>>> bench/palette_pixel_packet_parser_tb.sv
// Self-checking testbench for palette_pixel_packet_parser: status, update and
// pixel read beats checked against an in-bench predictor of the parser.
// Depends on ppp_pkg and the palette_pixel_packet_parser RTL.
`timescale 1ns / 100ps

module palette_pixel_packet_parser_tb;

    localparam int PAL_DEPTH    = ppp_pkg::PALETTE_DEPTH_DEF;
    localparam int PIX_DEPTH    = ppp_pkg::PIXEL_DEPTH_DEF;
    localparam int POS_CAP      = 1023;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BEATS = 250;
    localparam int HOLD_CYCLES  = 60;
    localparam int BIG_PAL      = 16;

    typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PATTERN } rx_mode_t;
    typedef enum int { FLAW_NONE, FLAW_BAD_INDEX, FLAW_SHORT } flaw_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       status_on;
        logic [7:0] pixel_count;
        logic [7:0] color_first;
        logic [7:0] color_second;
        logic [7:0] color_third;
    } result_t;

    typedef logic [7:0] byte_q_t [$];

    // block ports
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_we      = 1'b0;
    logic       cfg_index   = 1'b0;
    logic       cfg_data    = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic       cmd         = 1'b0;
    logic [7:0] data_byte   = 8'h00;
    logic       last_byte   = 1'b0;
    logic [7:0] pixel_index = 8'h00;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [1:0] kind;
    logic       status_on;
    logic [7:0] pixel_count;
    logic [7:0] color_first;
    logic [7:0] color_second;
    logic [7:0] color_third;

    palette_pixel_packet_parser uut (.*);

    // clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predicted parser state
    logic        upd_en    = 1'b0;
    logic        stat_en   = 1'b0;
    int          byte_pos  = 0;
    logic [7:0]  op_seen   = 8'h00;
    logic [7:0]  pal_len   = 8'h00;
    logic [7:0]  data_len  = 8'h00;
    logic [15:0] partial   = 16'h0000;
    logic        stat_val  = 1'b0;
    logic        idx_err   = 1'b0;
    logic [23:0] palette_mem [PAL_DEPTH];
    logic [23:0] pixel_mem   [PIX_DEPTH];
    bit          pix_known   [PIX_DEPTH];
    result_t     awaited_results [$];

    // traffic control and tallies
    bit       idle_on    = 1'b1;
    int       burst_left = 0;
    int       read_pct   = 0;
    rx_mode_t rx_mode    = RX_ALWAYS;
    int       hold_left  = 0;
    int       rx_tick    = 0;
    int       beats_sent = 0;
    int       results_seen = 0;
    int       n_status   = 0;
    int       n_update   = 0;
    int       n_pixel    = 0;
    int       mismatches = 0;

    // per-packet state back to idle
    function automatic void end_packet();
        byte_pos = 0;
        op_seen  = 8'h00;
        pal_len  = 8'h00;
        data_len = 8'h00;
        partial  = 16'h0000;
        stat_val = 1'b0;
        idx_err  = 1'b0;
    endfunction

    // one byte of an update packet past the opcode
    function automatic void update_byte(input logic [7:0] b);
        int off;
        int pal_bytes;
        int d;
        if (byte_pos == 1)
        begin
            pal_len = b;
            return;
        end
        if (byte_pos == 2)
        begin
            data_len = b;
            return;
        end
        off = byte_pos - 3;
        pal_bytes = 3 * int'(pal_len);
        if (off < pal_bytes)
        begin
            case (off % 3)
                0: partial = {b, 8'h00};
                1: partial[7:0] = b;
                default: if (off / 3 < PAL_DEPTH) palette_mem[off / 3] = {partial, b};
            endcase
            return;
        end
        d = off - pal_bytes;
        if (d < int'(data_len) && !idx_err)
        begin
            if (b >= pal_len)
            begin
                idx_err = 1'b1;
            end
            else if (d < PIX_DEPTH)
            begin
                pixel_mem[d] = (int'(b) < PAL_DEPTH) ? palette_mem[b] : 24'h0;
                // contents stay unknown until the update is accepted
                pix_known[d] = 1'b0;
            end
        end
    endfunction

    // advance the predicted parser by one accepted beat, queue any result
    function automatic void apply_beat(input logic c, input logic [7:0] b, input logic l,
                                       input logic [7:0] p);
        result_t r;
        int      total;
        int      need;
        r = '0;
        if (c)
        begin
            r.kind = ppp_pkg::KIND_PIXEL;
            if (int'(p) < PIX_DEPTH)
                {r.color_first, r.color_second, r.color_third} = pixel_mem[p];
            awaited_results.push_back(r);
            return;
        end
        if (byte_pos == 0)
            op_seen = b;
        else if (op_seen == ppp_pkg::OP_STATUS)
        begin
            if (byte_pos == 1)
                stat_val = (b != 8'h00);
        end
        else if (op_seen == ppp_pkg::OP_UPDATE)
            update_byte(b);
        total = byte_pos + 1;
        byte_pos = (total > POS_CAP) ? POS_CAP : total;
        if (!l)
            return;
        if (total >= 2 && op_seen == ppp_pkg::OP_STATUS)
        begin
            if (total == 2 && stat_en)
            begin
                r.kind = ppp_pkg::KIND_STATUS;
                r.status_on = stat_val;
                awaited_results.push_back(r);
            end
        end
        else if (total >= 2 && op_seen == ppp_pkg::OP_UPDATE)
        begin
            need = 3 + 3 * int'(pal_len) + int'(data_len);
            if (total >= need && !idx_err)
            begin
                // only a reported update makes pixels readable
                for (int i = 0; i < PIX_DEPTH; i++)
                    pix_known[i] = upd_en && (i < int'(data_len));
                if (upd_en)
                begin
                    r.kind = ppp_pkg::KIND_UPDATE;
                    r.pixel_count = data_len;
                    awaited_results.push_back(r);
                end
            end
        end
        end_packet();
    endfunction

    // random readable pixel, -1 when none
    function automatic int pick_known_pixel();
        int list [$];
        for (int i = 0; i < PIX_DEPTH; i++)
            if (pix_known[i])
                list.push_back(i);
        if (list.size() == 0)
            return -1;
        return list[$urandom_range(0, list.size() - 1)];
    endfunction

    // byte with extra weight on the extremes
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // update packet, optionally broken
    function automatic byte_q_t make_update(input int pal_n, input int dat_n, input int trail,
                                            input flaw_t flaw);
        byte_q_t q;
        int      cut;
        q.push_back(ppp_pkg::OP_UPDATE);
        q.push_back(8'(pal_n));
        q.push_back(8'(dat_n));
        for (int i = 0; i < 3 * pal_n; i++)
            q.push_back(rand_byte());
        for (int i = 0; i < dat_n; i++)
            q.push_back((pal_n > 0) ? 8'($urandom_range(0, pal_n - 1)) : rand_byte());
        if (flaw == FLAW_BAD_INDEX && dat_n > 0)
            q[3 + 3 * pal_n + $urandom_range(0, dat_n - 1)] = 8'($urandom_range(pal_n, 255));
        if (flaw == FLAW_SHORT)
        begin
            cut = $urandom_range(1, q.size() - 1);
            repeat (cut) void'(q.pop_back());
        end
        else
        begin
            repeat (trail) q.push_back(rand_byte());
        end
        return q;
    endfunction

    // input side: one beat, with bursty idling
    task automatic send_beat(input logic c, input logic [7:0] b, input logic l,
                             input logic [7:0] p);
        int gap;
        @(negedge clk);
        if (idle_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid    <= 1'b1;
        cmd         <= c;
        data_byte   <= b;
        last_byte   <= l;
        pixel_index <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
        apply_beat(c, b, l, p);
    endtask

    task automatic send_read(input int p);
        send_beat(1'b1, rand_byte(), 1'($urandom_range(0, 1)), 8'(p));
    endtask

    task automatic maybe_read();
        int p;
        if ($urandom_range(0, 99) < read_pct)
        begin
            p = pick_known_pixel();
            if (p >= 0)
                send_read(p);
        end
    endtask

    // packet bytes with reads mixed in
    task automatic send_packet(input byte_q_t q);
        foreach (q[i])
        begin
            maybe_read();
            send_beat(1'b0, q[i], i == q.size() - 1, 8'($urandom_range(0, 254)));
        end
    endtask

    // drop valid and let every result drain
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == ppp_pkg::CFG_UPDATE_EN)
            upd_en = val;
        else
            stat_en = val;
    endtask

    task automatic set_enables(input logic upd, input logic stat);
        wait_idle();
        write_reg(ppp_pkg::CFG_UPDATE_EN, upd);
        write_reg(ppp_pkg::CFG_STATUS_EN, stat);
    endtask

    // output side: ready pattern and long hold-offs
    always @(negedge clk)
    begin
        rx_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_RANDOM: out_ready <= ($urandom_range(0, 99) < 65);
                default:   out_ready <= ((rx_tick % 11) < 7);
            endcase
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {kind, status_on, pixel_count, color_first, color_second, color_third};
            results_seen++;
            case (got.kind)
                ppp_pkg::KIND_STATUS: n_status++;
                ppp_pkg::KIND_UPDATE: n_update++;
                default:              n_pixel++;
            endcase
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result kind %0d status %0b count %0d color %h%h%h",
                             $realtime, got.kind, got.status_on, got.pixel_count,
                             got.color_first, got.color_second, got.color_third);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: mismatch exp kind %0d status %0b count %0d color %h%h%h",
                                 $realtime, want.kind, want.status_on, want.pixel_count,
                                 want.color_first, want.color_second, want.color_third);
                        $display("    got kind %0d status %0b count %0d color %h%h%h",
                                 got.kind, got.status_on, got.pixel_count,
                                 got.color_first, got.color_second, got.color_third);
                    end
                end
            end
        end
    end

    // both enables still at reset: status packets stay silent
    task automatic test_reset_defaults();
        byte_q_t q;
        q = '{ppp_pkg::OP_STATUS, 8'h01};
        send_packet(q);
        q = '{ppp_pkg::OP_STATUS, 8'h00};
        send_packet(q);
    endtask

    // short, status, wrong length, unknown opcode, small update and reads
    task automatic test_directed();
        byte_q_t q;
        set_enables(1'b1, 1'b1);
        q = '{ppp_pkg::OP_UPDATE};
        send_packet(q);
        q = '{ppp_pkg::OP_STATUS};
        send_packet(q);
        q = '{ppp_pkg::OP_STATUS, 8'h00};
        send_packet(q);
        q = '{ppp_pkg::OP_STATUS, 8'hFF};
        send_packet(q);
        q = '{ppp_pkg::OP_STATUS, 8'h07, 8'h07};
        send_packet(q);
        q = '{8'hFF, 8'h01};
        send_packet(q);
        // two colors, three indices, one trailing byte
        q = '{ppp_pkg::OP_UPDATE, 8'd2, 8'd3, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h01,
              8'd1, 8'd0, 8'd1, 8'hAA};
        send_packet(q);
        for (int i = 0; i < 3; i++)
            send_read(i);
    endtask

    // full pixel count with trailing bytes, first and last palette entry used
    task automatic test_largest_update();
        byte_q_t q;
        q = make_update(BIG_PAL, 255, 3, FLAW_NONE);
        q[3 + 3 * BIG_PAL] = 8'd0;
        q[4 + 3 * BIG_PAL] = 8'(BIG_PAL - 1);
        send_packet(q);
        send_read(0);
        send_read(254);
        send_read(1);
        send_read(128);
        repeat (6) send_read($urandom_range(0, 254));
    endtask

    // one random packet, mostly well-formed updates
    task automatic send_random_packet();
        byte_q_t q;
        int      pick;
        int      pal_n;
        int      dat_n;
        int      extra;
        pick  = $urandom_range(0, 99);
        pal_n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
        dat_n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        extra = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4);
        if (pick < 52)
            q = make_update(pal_n, dat_n, extra, FLAW_NONE);
        else if (pick < 55)
            q = make_update(0, 0, extra, FLAW_NONE);
        else if (pick < 68)
        begin
            q.push_back(ppp_pkg::OP_STATUS);
            q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : rand_byte());
        end
        else if (pick < 78)
            q = make_update(pal_n, dat_n, 0, FLAW_BAD_INDEX);
        else if (pick < 85)
            q = make_update(pal_n, dat_n, 0, FLAW_SHORT);
        else if (pick < 90)
        begin
            q.push_back(ppp_pkg::OP_STATUS);
            repeat ($urandom_range(2, 4)) q.push_back(rand_byte());
        end
        else if (pick < 96)
        begin
            q.push_back(8'($urandom_range(2, 255)));
            repeat ($urandom_range(0, 6)) q.push_back(rand_byte());
        end
        else
            q.push_back(rand_byte());
        send_packet(q);
        maybe_read();
    endtask

    task automatic random_phase(input logic upd, input logic stat, input rx_mode_t mode,
                                input bit idling);
        int start;
        set_enables(upd, stat);
        rx_mode  = mode;
        idle_on  = idling;
        read_pct = 15;
        start    = beats_sent;
        while (beats_sent - start < RANDOM_BEATS / 5)
            send_random_packet();
    endtask

    // enable settings and output patterns in turn
    task automatic test_random_traffic();
        random_phase(1'b1, 1'b1, RX_RANDOM,  1'b1);
        random_phase(1'b0, 1'b1, RX_PATTERN, 1'b1);
        random_phase(1'b1, 1'b0, RX_ALWAYS,  1'b0);
        random_phase(1'b0, 1'b0, RX_RANDOM,  1'b1);
        random_phase(1'b1, 1'b1, RX_PATTERN, 1'b1);
    endtask

    // output held off while reads keep coming, input must stall
    task automatic test_backpressure();
        byte_q_t q;
        set_enables(1'b1, 1'b1);
        rx_mode  = RX_ALWAYS;
        idle_on  = 1'b0;
        read_pct = 0;
        q = make_update(4, 20, 0, FLAW_NONE);
        send_packet(q);
        hold_left = HOLD_CYCLES;
        repeat (30) send_read(pick_known_pixel());
        q = '{ppp_pkg::OP_STATUS, 8'h5A};
        send_packet(q);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_largest_update();
        test_random_traffic();
        test_backpressure();
        wait_idle();
        $display("%0d beats driven, %0d results checked: %0d status, %0d update, %0d pixel read",
                 beats_sent, results_seen, n_status, n_update, n_pixel);
        $display("covered all enable settings, broken packets, a full pixel count and hold-off");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
